// ===== rtl/csfs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Consensus site filter package
// Shared types, constants, register indexes and reset values.
// ----------------------------------------------------------------------------
package csfs_pkg;

    localparam int NumBins = 10;
    localparam int BinWidth = 4;
    localparam int ReportWidth = 48;
    localparam int CfgIndexWidth = 2;
    localparam int CfgDataWidth = 8;

    localparam logic [CfgIndexWidth-1:0] CFG_MIN_MAPQ  = 2'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_MIN_DEPTH = 2'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_MAX_DEPTH = 2'd2;
    localparam logic [CfgIndexWidth-1:0] CFG_MIN_NQ    = 2'd3;

    localparam logic [5:0] RESET_MIN_MAPQ  = 6'd40;
    localparam logic [7:0] RESET_MIN_DEPTH = 8'd3;
    localparam logic [7:0] RESET_MAX_DEPTH = 8'd255;
    localparam logic [5:0] RESET_MIN_NQ    = 6'd20;

    localparam logic [11:0] MIN_FRACTION = 12'd4;
    localparam logic [3:0]  N_BASE_CODE  = 4'hf;
    localparam logic [7:0]  BIN_STEP     = 8'd10;

    typedef struct packed {
        logic [5:0] mapq_floor;
        logic [7:0] depth_floor;
        logic [7:0] depth_ceiling;
        logic [5:0] nq_floor;
    } cfg_t;

    typedef struct packed {
        logic                site_passes;
        logic                is_n_base;
        logic [BinWidth-1:0] quality_bin;
    } site_t;

    // The bin is the number of multiples of ten that the quality reaches,
    // which also clamps everything at or above ninety into the last bin.
    function automatic logic [BinWidth-1:0] quality_bin_of(input logic [7:0] cq);
        logic [BinWidth-1:0] bin;
        bin = '0;
        for (int i = 1; i < NumBins; i++)
        begin
            if (cq >= 8'(i) * BIN_STEP)
            begin
                bin = bin + 4'd1;
            end
        end
        return bin;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/csfs_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Consensus site filter
// Unpacks one record and tests it against the configured limits.
// ----------------------------------------------------------------------------
module csfs_filter
(
    input  wire logic [31:0]    low_word,
    input  wire logic [31:0]    high_word,
    input  wire csfs_pkg::cfg_t cfg,
    output csfs_pkg::site_t     site
);

    logic [7:0]  depth;
    logic [5:0]  mapq;
    logic [5:0]  nq2;
    logic [11:0] fraction;
    logic [3:0]  base;
    logic [7:0]  cq;

    assign depth    = low_word[7:0];
    assign mapq     = low_word[13:8];
    assign nq2      = {low_word[19:15], 1'b0};
    assign fraction = low_word[31:20];
    assign base     = high_word[31:28];
    assign cq       = high_word[23:16];

    assign site.site_passes = (mapq >= cfg.mapq_floor)
                            && (fraction >= csfs_pkg::MIN_FRACTION)
                            && (depth >= cfg.depth_floor)
                            && (depth <= cfg.depth_ceiling)
                            && (nq2 >= cfg.nq_floor);
    assign site.is_n_base   = (base == csfs_pkg::N_BASE_CODE);
    assign site.quality_bin = csfs_pkg::quality_bin_of(cq);

endmodule
`default_nettype wire

// ===== rtl/csfs_stats.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Consensus site statistics
// Saturating site counters and cumulative quality histogram counts.
// ----------------------------------------------------------------------------
module csfs_stats
#(
    parameter int COUNT_WIDTH = 48
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              update,
    input  wire csfs_pkg::site_t                   site,
    input  wire logic [csfs_pkg::BinWidth-1:0]     report_bin,
    output logic [COUNT_WIDTH-1:0]                 good_next,
    output logic [COUNT_WIDTH-1:0]                 n_next,
    output logic [COUNT_WIDTH-1:0]                 non_n_next,
    output logic [COUNT_WIDTH-1:0]                 at_or_above_next
);

    // Each entry holds the saturated sum of histogram bins from its own
    // index up to the last bin, so a passing site bumps every entry at or
    // below its bin and the cumulative count is a single lookup.
    logic [COUNT_WIDTH-1:0] good_reg;
    logic [COUNT_WIDTH-1:0] n_reg;
    logic [COUNT_WIDTH-1:0] non_n_reg;
    logic [COUNT_WIDTH-1:0] suffix_reg  [csfs_pkg::NumBins];
    logic [COUNT_WIDTH-1:0] suffix_next [csfs_pkg::NumBins];

    always_comb
    begin
        good_next  = good_reg;
        n_next     = n_reg;
        non_n_next = non_n_reg;
        if (site.site_passes && !(&good_reg)) begin
            good_next = good_reg + 1'b1;
        end
        if (site.is_n_base && !(&n_reg)) begin
            n_next = n_reg + 1'b1;
        end
        if (!site.is_n_base && !(&non_n_reg)) begin
            non_n_next = non_n_reg + 1'b1;
        end
        for (int k = 0; k < csfs_pkg::NumBins; k++) begin
            suffix_next[k] = suffix_reg[k];
            if (site.site_passes && (csfs_pkg::BinWidth'(k) <= site.quality_bin)
                && !(&suffix_reg[k])) begin
                suffix_next[k] = suffix_reg[k] + 1'b1;
            end
        end
        if (report_bin < csfs_pkg::BinWidth'(csfs_pkg::NumBins)) begin
            at_or_above_next = suffix_next[report_bin];
        end
        else begin
            at_or_above_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            good_reg  <= '0;
            n_reg     <= '0;
            non_n_reg <= '0;
            for (int k = 0; k < csfs_pkg::NumBins; k++) begin
                suffix_reg[k] <= '0;
            end
        end
        else if (update) begin
            good_reg  <= good_next;
            n_reg     <= n_next;
            non_n_reg <= non_n_next;
            for (int k = 0; k < csfs_pkg::NumBins; k++) begin
                suffix_reg[k] <= suffix_next[k];
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/consensus_site_filter_stats.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: an accepted word is held in the input register and its result word moves into
// the result register when the output is not stalled. Throughput: one word per cycle while
// the output is not stalled; the input register and the result register move together, so
// a stalled output holds both stages and releases them in the same cycle.
// Reset clears all counters and histogram sums and loads the register reset values.
// ----------------------------------------------------------------------------
// Consensus site filter with running statistics
// Filters packed consensus records and reports saturating site counts.
// ----------------------------------------------------------------------------
module consensus_site_filter_stats
#(
    parameter int COUNT_WIDTH = 48
)
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_write,
    input  wire logic [csfs_pkg::CfgIndexWidth-1:0]     cfg_index,
    input  wire logic [csfs_pkg::CfgDataWidth-1:0]      cfg_data,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic [31:0]                            low_word,
    input  wire logic [31:0]                            high_word,
    input  wire logic [csfs_pkg::BinWidth-1:0]          report_bin,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic                                        site_passes,
    output logic                                        is_n_base,
    output logic [csfs_pkg::BinWidth-1:0]               quality_bin,
    output logic [csfs_pkg::ReportWidth-1:0]            good_count,
    output logic [csfs_pkg::ReportWidth-1:0]            n_count,
    output logic [csfs_pkg::ReportWidth-1:0]            non_n_count,
    output logic [csfs_pkg::ReportWidth-1:0]            good_at_or_above
);

    localparam int PadWidth = COUNT_WIDTH + csfs_pkg::ReportWidth;

    csfs_pkg::cfg_t cfg_reg;

    logic                              s1_valid_reg;
    logic [31:0]                       low_word_reg;
    logic [31:0]                       high_word_reg;
    logic [csfs_pkg::BinWidth-1:0]     report_bin_reg;

    logic                              out_valid_reg;
    csfs_pkg::site_t                   site_reg;
    logic [csfs_pkg::ReportWidth-1:0]  good_reg;
    logic [csfs_pkg::ReportWidth-1:0]  n_reg;
    logic [csfs_pkg::ReportWidth-1:0]  non_n_reg;
    logic [csfs_pkg::ReportWidth-1:0]  at_or_above_reg;

    logic                              advance;
    logic                              update;
    csfs_pkg::site_t                   site;
    logic [COUNT_WIDTH-1:0]            good_next;
    logic [COUNT_WIDTH-1:0]            n_next;
    logic [COUNT_WIDTH-1:0]            non_n_next;
    logic [COUNT_WIDTH-1:0]            at_or_above_next;
    logic [PadWidth-1:0]               good_pad;
    logic [PadWidth-1:0]               n_pad;
    logic [PadWidth-1:0]               non_n_pad;
    logic [PadWidth-1:0]               at_or_above_pad;

    assign advance  = !out_valid_reg || out_ready;
    assign update   = s1_valid_reg && advance;
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mapq_floor    <= csfs_pkg::RESET_MIN_MAPQ;
            cfg_reg.depth_floor   <= csfs_pkg::RESET_MIN_DEPTH;
            cfg_reg.depth_ceiling <= csfs_pkg::RESET_MAX_DEPTH;
            cfg_reg.nq_floor      <= csfs_pkg::RESET_MIN_NQ;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                csfs_pkg::CFG_MIN_MAPQ:  cfg_reg.mapq_floor    <= cfg_data[5:0];
                csfs_pkg::CFG_MIN_DEPTH: cfg_reg.depth_floor   <= cfg_data;
                csfs_pkg::CFG_MAX_DEPTH: cfg_reg.depth_ceiling <= cfg_data;
                csfs_pkg::CFG_MIN_NQ:    cfg_reg.nq_floor      <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            low_word_reg   <= low_word;
            high_word_reg  <= high_word;
            report_bin_reg <= report_bin;
        end
        if (update)
        begin
            site_reg        <= site;
            good_reg        <= good_pad[csfs_pkg::ReportWidth-1:0];
            n_reg           <= n_pad[csfs_pkg::ReportWidth-1:0];
            non_n_reg       <= non_n_pad[csfs_pkg::ReportWidth-1:0];
            at_or_above_reg <= at_or_above_pad[csfs_pkg::ReportWidth-1:0];
        end
    end

    csfs_filter u_filter
    (
        .low_word  (low_word_reg),
        .high_word (high_word_reg),
        .cfg       (cfg_reg),
        .site      (site)
    );

    csfs_stats
    #(
        .COUNT_WIDTH (COUNT_WIDTH)
    )
    u_stats
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .update           (update),
        .site             (site),
        .report_bin       (report_bin_reg),
        .good_next        (good_next),
        .n_next           (n_next),
        .non_n_next       (non_n_next),
        .at_or_above_next (at_or_above_next)
    );

    assign good_pad        = {{csfs_pkg::ReportWidth{1'b0}}, good_next};
    assign n_pad           = {{csfs_pkg::ReportWidth{1'b0}}, n_next};
    assign non_n_pad       = {{csfs_pkg::ReportWidth{1'b0}}, non_n_next};
    assign at_or_above_pad = {{csfs_pkg::ReportWidth{1'b0}}, at_or_above_next};

    assign out_valid        = out_valid_reg;
    assign site_passes      = site_reg.site_passes;
    assign is_n_base        = site_reg.is_n_base;
    assign quality_bin      = site_reg.quality_bin;
    assign good_count       = good_reg;
    assign n_count          = n_reg;
    assign non_n_count      = non_n_reg;
    assign good_at_or_above = at_or_above_reg;

endmodule
`default_nettype wire

// ===== tb/sv/consensus_site_filter_stats_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Consensus site filter testbench
// Streams packed consensus records through the filter under several limit
// settings and random handshake gaps, and checks every result word against
// an in-bench scoreboard of the filter and its saturating site statistics.
// ----------------------------------------------------------------------------
module consensus_site_filter_stats_tb;
    import csfs_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES = 10;
    localparam int PHASE_SITES = 53;
    localparam int LONG_HOLD = 80;
    localparam logic [ReportWidth-1:0] COUNT_MAX = '1;

    typedef struct {
        logic [31:0]         low;
        logic [31:0]         high;
        logic [BinWidth-1:0] rbin;
    } site_record_t;

    typedef struct packed {
        logic                   site_passes;
        logic                   is_n_base;
        logic [BinWidth-1:0]    quality_bin;
        logic [ReportWidth-1:0] good_count;
        logic [ReportWidth-1:0] n_count;
        logic [ReportWidth-1:0] non_n_count;
        logic [ReportWidth-1:0] good_at_or_above;
    } site_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [CfgIndexWidth-1:0] cfg_index = '0;
    logic [CfgDataWidth-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [31:0] low_word = '0;
    logic [31:0] high_word = '0;
    logic [BinWidth-1:0] report_bin = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic site_passes;
    logic is_n_base;
    logic [BinWidth-1:0] quality_bin;
    logic [ReportWidth-1:0] good_count;
    logic [ReportWidth-1:0] n_count;
    logic [ReportWidth-1:0] non_n_count;
    logic [ReportWidth-1:0] good_at_or_above;

    cfg_t site_limits;
    logic [ReportWidth-1:0] passing_total = '0;
    logic [ReportWidth-1:0] n_total = '0;
    logic [ReportWidth-1:0] non_n_total = '0;
    logic [ReportWidth-1:0] quality_hist [NumBins];

    site_record_t pending_records [$];
    site_result_t expected_sites [$];
    site_record_t offered_record;
    int unsigned gap_mode = 0;
    int unsigned send_gap = 0;
    int unsigned recv_stall = 0;
    logic hold_output = 1'b0;
    int unsigned errors = 0;
    int unsigned cycle_count = 0;

    consensus_site_filter_stats #(
        .COUNT_WIDTH(48)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .low_word(low_word),
        .high_word(high_word),
        .report_bin(report_bin),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .site_passes(site_passes),
        .is_n_base(is_n_base),
        .quality_bin(quality_bin),
        .good_count(good_count),
        .n_count(n_count),
        .non_n_count(non_n_count),
        .good_at_or_above(good_at_or_above)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [ReportWidth-1:0] bump(input logic [ReportWidth-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    // Updates the running statistics with one record and returns its result word.
    function automatic site_result_t score_site(input site_record_t rec);
        site_result_t res;
        logic [7:0] depth;
        logic [5:0] mapq;
        logic [5:0] nq2;
        logic [11:0] frac;
        logic [7:0] cq;
        logic [63:0] sum;
        depth = rec.low[7:0];
        mapq = rec.low[13:8];
        nq2 = {rec.low[19:15], 1'b0};
        frac = rec.low[31:20];
        cq = rec.high[23:16];
        if (cq > 8'd99)
        begin
            cq = 8'd99;
        end
        res.quality_bin = BinWidth'(cq / 8'd10);
        res.is_n_base = (rec.high[31:28] == N_BASE_CODE);
        if (res.is_n_base)
        begin
            n_total = bump(n_total);
        end
        else
        begin
            non_n_total = bump(non_n_total);
        end
        res.site_passes = (mapq >= site_limits.mapq_floor) && (frac >= MIN_FRACTION)
            && (depth >= site_limits.depth_floor) && (depth <= site_limits.depth_ceiling)
            && (nq2 >= site_limits.nq_floor);
        if (res.site_passes)
        begin
            passing_total = bump(passing_total);
            quality_hist[res.quality_bin] = bump(quality_hist[res.quality_bin]);
        end
        sum = '0;
        for (int i = 0; i < NumBins; i++)
        begin
            if (i >= rec.rbin)
            begin
                sum = sum + quality_hist[i];
                if (sum > COUNT_MAX)
                begin
                    sum = COUNT_MAX;
                end
            end
        end
        res.good_count = passing_total;
        res.n_count = n_total;
        res.non_n_count = non_n_total;
        res.good_at_or_above = sum[ReportWidth-1:0];
        return res;
    endfunction

    function automatic int unsigned pick_gap(input int unsigned mode);
        int unsigned r;
        if (mode == 0)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 92 || mode == 1)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic site_record_t make_site(input logic [7:0] depth, input logic [5:0] mapq,
                                               input logic [4:0] nq, input logic [11:0] frac,
                                               input logic [3:0] base, input logic [7:0] cq,
                                               input logic [BinWidth-1:0] rbin);
        site_record_t rec;
        rec.low = $urandom;
        rec.high = $urandom;
        rec.low[7:0] = depth;
        rec.low[13:8] = mapq;
        rec.low[19:15] = nq;
        rec.low[31:20] = frac;
        rec.high[31:28] = base;
        rec.high[23:16] = cq;
        rec.rbin = rbin;
        return rec;
    endfunction

    // Most records are built to pass the current limits, a few of those get one
    // field spoiled, and the rest are raw random words.
    function automatic site_record_t random_record();
        site_record_t rec;
        logic [7:0] depth;
        logic [5:0] mapq;
        logic [4:0] nq;
        logic [11:0] frac;
        int unsigned nq_low;
        int unsigned pick;
        rec.low = $urandom;
        rec.high = $urandom;
        rec.rbin = ($urandom_range(0, 7) == 0) ? BinWidth'($urandom_range(10, 15))
                                               : BinWidth'($urandom_range(0, 9));
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            depth = (site_limits.depth_floor <= site_limits.depth_ceiling)
                ? 8'($urandom_range(site_limits.depth_ceiling, site_limits.depth_floor))
                : 8'($urandom);
            mapq = 6'($urandom_range(63, site_limits.mapq_floor));
            nq_low = (int'(site_limits.nq_floor) + 1) / 2;
            nq = (nq_low > 31) ? 5'($urandom) : 5'($urandom_range(31, nq_low));
            frac = 12'($urandom_range(4095, 4));
            if (pick < 20)
            begin
                case ($urandom_range(0, 3))
                    0: depth = 8'($urandom);
                    1: mapq = 6'($urandom);
                    2: nq = 5'($urandom);
                    default: frac = 12'($urandom_range(0, 4));
                endcase
            end
            rec.low[7:0] = depth;
            rec.low[13:8] = mapq;
            rec.low[19:15] = nq;
            rec.low[31:20] = frac;
        end
        rec.high[31:28] = ($urandom_range(0, 3) == 0) ? N_BASE_CODE : 4'($urandom);
        rec.high[23:16] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 110));
        return rec;
    endfunction

    task automatic check_field(input string name, input logic [ReportWidth-1:0] want,
                               input logic [ReportWidth-1:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic write_limit(input logic [CfgIndexWidth-1:0] idx,
                               input logic [CfgDataWidth-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_MIN_MAPQ: site_limits.mapq_floor = data[5:0];
            CFG_MIN_DEPTH: site_limits.depth_floor = data;
            CFG_MAX_DEPTH: site_limits.depth_ceiling = data;
            CFG_MIN_NQ: site_limits.nq_floor = data[5:0];
            default: ;
        endcase
    endtask

    task automatic write_limits(input logic [7:0] mapq_lo, input logic [7:0] depth_lo,
                                input logic [7:0] depth_hi, input logic [7:0] nq_lo);
        write_limit(CFG_MIN_MAPQ, mapq_lo);
        write_limit(CFG_MIN_DEPTH, depth_lo);
        write_limit(CFG_MAX_DEPTH, depth_hi);
        write_limit(CFG_MIN_NQ, nq_lo);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (pending_records.size() != 0 || in_valid || expected_sites.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    always @(posedge clk)
    begin : drive_sites
        logic next_valid;
        if (rst_n)
        begin
            next_valid = in_valid;
            if (in_valid && in_ready)
            begin
                expected_sites.push_back(score_site(offered_record));
                next_valid = 1'b0;
                send_gap = pick_gap(gap_mode);
            end
            if (!next_valid)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                end
                else if (pending_records.size() > 0)
                begin
                    offered_record = pending_records.pop_front();
                    low_word <= offered_record.low;
                    high_word <= offered_record.high;
                    report_bin <= offered_record.rbin;
                    next_valid = 1'b1;
                end
            end
            in_valid <= next_valid;
        end
    end

    always @(posedge clk)
    begin : collect_sites
        site_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_sites.size() == 0)
                begin
                    $display("%0t ns: result word with nothing expected, expected none, got %0d",
                             $time, good_count);
                    errors++;
                end
                else
                begin
                    want = expected_sites.pop_front();
                    check_field("site_passes", 48'(want.site_passes), 48'(site_passes));
                    check_field("is_n_base", 48'(want.is_n_base), 48'(is_n_base));
                    check_field("quality_bin", 48'(want.quality_bin), 48'(quality_bin));
                    check_field("good_count", want.good_count, good_count);
                    check_field("n_count", want.n_count, n_count);
                    check_field("non_n_count", want.non_n_count, non_n_count);
                    check_field("good_at_or_above", want.good_at_or_above, good_at_or_above);
                end
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                out_ready <= 1'b0;
            end
            else if (hold_output)
            begin
                out_ready <= 1'b0;
            end
            else
            begin
                recv_stall = pick_gap(gap_mode);
                out_ready <= (recv_stall == 0);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        site_limits.mapq_floor = RESET_MIN_MAPQ;
        site_limits.depth_floor = RESET_MIN_DEPTH;
        site_limits.depth_ceiling = RESET_MAX_DEPTH;
        site_limits.nq_floor = RESET_MIN_NQ;
        for (int i = 0; i < NumBins; i++)
        begin
            quality_hist[i] = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Boundaries of every limit at the reset settings, quality bin edges and
        // report bins past the last bin.
        pending_records.push_back('{low: 32'h0, high: 32'h0, rbin: 4'd0});
        pending_records.push_back('{low: 32'hffff_ffff, high: 32'hffff_ffff, rbin: 4'd15});
        pending_records.push_back(make_site(8'd3, 6'd40, 5'd10, 12'd4, 4'd0, 8'd99, 4'd9));
        pending_records.push_back(make_site(8'd2, 6'd40, 5'd10, 12'd4, 4'd1, 8'd50, 4'd0));
        pending_records.push_back(make_site(8'd255, 6'd40, 5'd10, 12'd4, 4'd2, 8'd45, 4'd4));
        pending_records.push_back(make_site(8'd3, 6'd39, 5'd10, 12'd4, 4'd3, 8'd70, 4'd0));
        pending_records.push_back(make_site(8'd3, 6'd40, 5'd9, 12'd4, 4'd4, 8'd70, 4'd0));
        pending_records.push_back(make_site(8'd3, 6'd40, 5'd10, 12'd3, 4'd5, 8'd70, 4'd0));
        pending_records.push_back(make_site(8'd100, 6'd63, 5'd31, 12'hfff, 4'd15, 8'd0, 4'd0));
        pending_records.push_back(make_site(8'd50, 6'd45, 5'd12, 12'd8, 4'd14, 8'd9, 4'd1));
        pending_records.push_back(make_site(8'd50, 6'd45, 5'd12, 12'd8, 4'd6, 8'd10, 4'd1));
        pending_records.push_back(make_site(8'd50, 6'd45, 5'd12, 12'd8, 4'd7, 8'd89, 4'd8));
        pending_records.push_back(make_site(8'd50, 6'd45, 5'd12, 12'd8, 4'd8, 8'd90, 4'd9));
        pending_records.push_back(make_site(8'd50, 6'd45, 5'd12, 12'd8, 4'd9, 8'd100, 4'd10));
        pending_records.push_back(make_site(8'd50, 6'd45, 5'd12, 12'd8, 4'd15, 8'd255, 4'd12));
        pending_records.push_back(make_site(8'd50, 6'd45, 5'd12, 12'd8, 4'd10, 8'd25, 4'd2));
        pending_records.push_back(make_site(8'd50, 6'd45, 5'd12, 12'd8, 4'd11, 8'd35, 4'd3));
        pending_records.push_back(make_site(8'd50, 6'd45, 5'd12, 12'd8, 4'd12, 8'd55, 4'd5));
        pending_records.push_back(make_site(8'd50, 6'd45, 5'd12, 12'd8, 4'd13, 8'd65, 4'd6));
        pending_records.push_back(make_site(8'd50, 6'd45, 5'd12, 12'd8, 4'd0, 8'd75, 4'd7));
        wait_drained();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: write_limits(8'h00, 8'h00, 8'h00, 8'h00);
                1: write_limits(8'hff, 8'hff, 8'hff, 8'hff);
                2: write_limits(8'($urandom_range(0, 20)), 8'd200, 8'd100,
                                8'($urandom_range(0, 20)));
                3: write_limits(8'(RESET_MIN_MAPQ), RESET_MIN_DEPTH, RESET_MAX_DEPTH,
                                8'(RESET_MIN_NQ));
                default: write_limits(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            endcase
            @(negedge clk);
            gap_mode = phase % 3;
            for (int k = 0; k < PHASE_SITES; k++)
            begin
                pending_records.push_back(random_record());
            end
            if (phase == 5)
            begin
                // The sender keeps offering while the result side is held off,
                // so the pipeline fills and backs up into the input.
                hold_output = 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                hold_output = 1'b0;
            end
            wait_drained();
        end

        repeat (10) @(negedge clk);
        if (errors == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
